### sv/bfmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfmd_pkg
// Shared types and constants for the box filter mipmap downsampler.
// ----------------------------------------------------------------------------
package bfmd_pkg;

    // Default sizing handed to the top level parameters.
    localparam int DEF_MAX_DST_WIDTH = 2048;
    localparam int DEF_MAX_FACTOR    = 8;

    // Pixel format.
    localparam int PIX_W  = 8;
    localparam int NUM_CH = 4;

    // Configuration register widths and port sizing.
    localparam int DST_WIDTH_W = 12;
    localparam int FACTOR_W    = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FACTOR_X  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FACTOR_Y  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_ALPHA = 2'd3;

    // Configuration reset values.
    localparam logic [DST_WIDTH_W-1:0] RST_DST_WIDTH = 12'd1;
    localparam logic [FACTOR_W-1:0]    RST_FACTOR_X  = 4'd2;
    localparam logic [FACTOR_W-1:0]    RST_FACTOR_Y  = 4'd2;
    localparam logic                   RST_HAS_ALPHA = 1'b0;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Control state: reciprocal of the block area being computed, or running.
    typedef enum logic [0:0] {
        ST_RECIP,
        ST_RUN
    } state_t;

    // One output pixel as it sits in the result queue.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             row_end;
    } result_t;

endpackage
`default_nettype wire

### sv/box_filter_mipmap_downsampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_mipmap_downsampler_core
// Integer factor box filter that averages factor_x by factor_y pixel blocks.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the pix channel (pix_valid/pix_stall),
// one beat per pixel. Each closed block leaves as one beat on the res channel
// (res_valid/res_stall), with row_end marking the last pixel of an output row.
// Configuration registers are written via cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which it does not enforce.
// Every write restarts the frame position.
// The block takes one pixel per cycle while pix_stall is low. Column sums live
// in one RAM entry per output column: a pixel reads its entry on acceptance
// and writes it back in the next cycle, with the last written value forwarded
// to the next pixel. Each result passes stages 1 to 3 into the result queue.
//
// After reset and after each configuration write, the reciprocal of the block
// area is computed bit by bit, and pix_stall stays high meanwhile. Results
// queue in an eight beat buffer; when the receiver stalls, pix_stall rises
// once the buffer plus the results still in the pipeline would fill it, so
// no beat is lost.
// ----------------------------------------------------------------------------
module box_filter_mipmap_downsampler_core #(
    parameter int MAX_DST_WIDTH = bfmd_pkg::DEF_MAX_DST_WIDTH,
    parameter int MAX_FACTOR    = bfmd_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               pix_valid,
    output logic                                    pix_stall,
    input  wire logic [bfmd_pkg::PIX_W-1:0]         red_in,
    input  wire logic [bfmd_pkg::PIX_W-1:0]         green_in,
    input  wire logic [bfmd_pkg::PIX_W-1:0]         blue_in,
    input  wire logic [bfmd_pkg::PIX_W-1:0]         alpha_in,

    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output logic      [bfmd_pkg::PIX_W-1:0]         red_out,
    output logic      [bfmd_pkg::PIX_W-1:0]         green_out,
    output logic      [bfmd_pkg::PIX_W-1:0]         blue_out,
    output logic      [bfmd_pkg::PIX_W-1:0]         alpha_out,
    output logic                                    row_end,

    input  wire logic                               cfg_we,
    input  wire logic [bfmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bfmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PIX_W   = bfmd_pkg::PIX_W;
    localparam int NUM_CH  = bfmd_pkg::NUM_CH;
    localparam int SUM_W   = PIX_W + $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int AREA_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int FACT_W  = $clog2(MAX_FACTOR + 1);
    localparam int POS_W   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int DW_W    = $clog2(MAX_DST_WIDTH + 1);
    localparam int COL_W   = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int RECIP_W = SUM_W + 1;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int MEM_W   = NUM_CH * SUM_W;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int CHK_W   = SUM_W + AREA_W;
    localparam int OCC_W   = bfmd_pkg::FIFO_CNT_W + 1;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_vec_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bfmd_pkg::DST_WIDTH_W-1:0] dst_width_reg;
    logic [bfmd_pkg::FACTOR_W-1:0]    factor_x_reg;
    logic [bfmd_pkg::FACTOR_W-1:0]    factor_y_reg;
    logic                             has_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_width_reg <= bfmd_pkg::RST_DST_WIDTH;
            factor_x_reg  <= bfmd_pkg::RST_FACTOR_X;
            factor_y_reg  <= bfmd_pkg::RST_FACTOR_Y;
            has_alpha_reg <= bfmd_pkg::RST_HAS_ALPHA;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfmd_pkg::REG_DST_WIDTH:
                    dst_width_reg <= cfg_data[bfmd_pkg::DST_WIDTH_W-1:0];
                bfmd_pkg::REG_FACTOR_X:
                    factor_x_reg <= cfg_data[bfmd_pkg::FACTOR_W-1:0];
                bfmd_pkg::REG_FACTOR_Y:
                    factor_y_reg <= cfg_data[bfmd_pkg::FACTOR_W-1:0];
                bfmd_pkg::REG_HAS_ALPHA:
                    has_alpha_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Zero acts as one and oversized values saturate at the maximum.
    logic [DW_W-1:0]   w_eff;
    logic [FACT_W-1:0] fx_eff;
    logic [FACT_W-1:0] fy_eff;
    logic [AREA_W-1:0] area;

    always_comb
    begin
        if (dst_width_reg == '0)
            w_eff = DW_W'(1);
        else if (32'(dst_width_reg) > MAX_DST_WIDTH)
            w_eff = DW_W'(MAX_DST_WIDTH);
        else
            w_eff = DW_W'(dst_width_reg);

        if (factor_x_reg == '0)
            fx_eff = FACT_W'(1);
        else if (32'(factor_x_reg) > MAX_FACTOR)
            fx_eff = FACT_W'(MAX_FACTOR);
        else
            fx_eff = FACT_W'(factor_x_reg);

        if (factor_y_reg == '0)
            fy_eff = FACT_W'(1);
        else if (32'(factor_y_reg) > MAX_FACTOR)
            fy_eff = FACT_W'(MAX_FACTOR);
        else
            fy_eff = FACT_W'(factor_y_reg);

        area = AREA_W'(AREA_W'(fx_eff) * AREA_W'(fy_eff));
    end

    // ------------------------------------------------------------------
    // Reciprocal of the area: floor(2^SUM_W / area), one bit per cycle
    // ------------------------------------------------------------------
    bfmd_pkg::state_t state_reg;
    bfmd_pkg::state_t state_next;
    logic             busy;

    logic [STEP_W-1:0]  step_reg;
    logic [AREA_W-1:0]  div_rem_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [AREA_W:0]    div_trial;
    logic               div_ge;
    logic [AREA_W:0]    div_diff;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfmd_pkg::ST_RECIP:
                if (step_reg == '0)
                    state_next = bfmd_pkg::ST_RUN;
            bfmd_pkg::ST_RUN:
                state_next = bfmd_pkg::ST_RUN;
            default:
                state_next = bfmd_pkg::ST_RECIP;
        endcase
        if (cfg_we)
            state_next = bfmd_pkg::ST_RECIP;
    end

    always_comb
    begin
        unique case (state_reg)
            bfmd_pkg::ST_RECIP: busy = 1'b1;
            bfmd_pkg::ST_RUN:   busy = 1'b0;
            default:            busy = 1'b1;
        endcase
    end

    // The dividend is a single one at bit SUM_W, so only the first step
    // shifts in a one.
    assign div_trial = {div_rem_reg, (step_reg == STEP_W'(SUM_W))};
    assign div_ge    = (div_trial >= {1'b0, area});
    assign div_diff  = div_trial - {1'b0, area};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bfmd_pkg::ST_RECIP;
            step_reg    <= STEP_W'(SUM_W);
            div_rem_reg <= '0;
            recip_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                step_reg    <= STEP_W'(SUM_W);
                div_rem_reg <= '0;
                recip_reg   <= '0;
            end
            else if (busy)
            begin
                step_reg    <= step_reg - STEP_W'(1);
                div_rem_reg <= div_ge ? div_diff[AREA_W-1:0] : div_trial[AREA_W-1:0];
                recip_reg   <= {recip_reg[RECIP_W-2:0], div_ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance and block position
    // ------------------------------------------------------------------
    logic                         pix_accept;
    logic [POS_W-1:0]             cib_reg;
    logic [POS_W-1:0]             rib_reg;
    logic [COL_W-1:0]             col_reg;
    logic                         last_cx;
    logic                         last_ry;
    logic                         last_col;

    logic                         s1_valid_reg;
    logic                         s1_close_reg;
    logic                         s2_valid_reg;
    logic                         s3_valid_reg;
    logic [bfmd_pkg::FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [OCC_W-1:0]             occupancy;

    // Results still in flight count against the queue before they land.
    assign occupancy = OCC_W'(fifo_cnt_reg)
                     + OCC_W'(s1_valid_reg && s1_close_reg)
                     + OCC_W'(s2_valid_reg)
                     + OCC_W'(s3_valid_reg);

    assign pix_stall  = busy || (occupancy >= OCC_W'(bfmd_pkg::FIFO_DEPTH));
    assign pix_accept = pix_valid && !pix_stall;

    assign last_cx  = (FACT_W'(cib_reg) == fx_eff - FACT_W'(1));
    assign last_ry  = (FACT_W'(rib_reg) == fy_eff - FACT_W'(1));
    assign last_col = (DW_W'(col_reg) == w_eff - DW_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cib_reg <= '0;
            rib_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_we)
        begin
            cib_reg <= '0;
            rib_reg <= '0;
            col_reg <= '0;
        end
        else if (pix_accept)
        begin
            if (last_cx)
            begin
                cib_reg <= '0;
                if (last_col)
                begin
                    col_reg <= '0;
                    rib_reg <= last_ry ? '0 : rib_reg + POS_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            else
            begin
                cib_reg <= cib_reg + POS_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: column sum read, add and write back
    // ------------------------------------------------------------------
    logic [COL_W-1:0] s1_addr_reg;
    pix_vec_t         s1_pix_reg;
    logic             s1_first_reg;
    logic             s1_row_end_reg;

    logic [MEM_W-1:0] ram_rd_data;
    logic             fwd_valid_reg;
    logic [COL_W-1:0] fwd_addr_reg;
    sum_vec_t         fwd_data_reg;
    sum_vec_t         s1_base;
    sum_vec_t         s1_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= pix_accept;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_addr_reg    <= col_reg;
            s1_pix_reg     <= {(has_alpha_reg ? alpha_in : '0), blue_in, green_in, red_in};
            s1_first_reg   <= (cib_reg == '0) && (rib_reg == '0);
            s1_close_reg   <= last_cx && last_ry;
            s1_row_end_reg <= last_col;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= s1_sum;
    end

    bfmd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_DST_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .we      (s1_valid_reg),
        .waddr   (s1_addr_reg),
        .wdata   (s1_sum),
        .re      (pix_accept),
        .raddr   (col_reg),
        .rd_data (ram_rd_data)
    );

    // The RAM read for this pixel overlapped the previous pixel's write, so
    // that write is taken from the forwarding register instead.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
            s1_base = fwd_data_reg;
        else
            s1_base = ram_rd_data;

        for (int c = 0; c < NUM_CH; c++)
        begin
            if (s1_first_reg)
                s1_sum[c] = SUM_W'(s1_pix_reg[c]);
            else
                s1_sum[c] = s1_base[c] + SUM_W'(s1_pix_reg[c]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply by the reciprocal
    // ------------------------------------------------------------------
    sum_vec_t s2_sum_reg;
    logic     s2_row_end_reg;
    sum_vec_t s2_q0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && s1_close_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_sum_reg     <= s1_sum;
        s2_row_end_reg <= s1_row_end_reg;
    end

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod     = PROD_W'(s2_sum_reg[c]) * PROD_W'(recip_reg);
            s2_q0[c] = prod[SUM_W +: SUM_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the estimate is the quotient or one below it; fix it up
    // ------------------------------------------------------------------
    sum_vec_t s3_sum_reg;
    sum_vec_t s3_q0_reg;
    logic     s3_row_end_reg;
    sum_vec_t s3_rem;
    pix_vec_t s3_avg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_sum_reg     <= s2_sum_reg;
        s3_q0_reg      <= s2_q0;
        s3_row_end_reg <= s2_row_end_reg;
    end

    always_comb
    begin
        logic [CHK_W-1:0] back;
        logic [SUM_W-1:0] quo;
        for (int c = 0; c < NUM_CH; c++)
        begin
            back      = CHK_W'(s3_q0_reg[c]) * CHK_W'(area);
            s3_rem[c] = s3_sum_reg[c] - back[SUM_W-1:0];
            quo       = s3_q0_reg[c] + SUM_W'(s3_rem[c] >= SUM_W'(area));
            s3_avg[c] = quo[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    bfmd_pkg::result_t               fifo_mem [bfmd_pkg::FIFO_DEPTH];
    logic [bfmd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [bfmd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic                            res_pop;
    bfmd_pkg::result_t               head;

    assign res_valid = (fifo_cnt_reg != '0);
    assign res_pop   = res_valid && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (s3_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + bfmd_pkg::FIFO_PTR_W'(1);
            if (res_pop)
                rd_ptr_reg <= rd_ptr_reg + bfmd_pkg::FIFO_PTR_W'(1);
            if (s3_valid_reg && !res_pop)
                fifo_cnt_reg <= fifo_cnt_reg + bfmd_pkg::FIFO_CNT_W'(1);
            else if (!s3_valid_reg && res_pop)
                fifo_cnt_reg <= fifo_cnt_reg - bfmd_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= '{red:     s3_avg[0],
                                      green:   s3_avg[1],
                                      blue:    s3_avg[2],
                                      alpha:   s3_avg[3],
                                      row_end: s3_row_end_reg};
        end
    end

    assign head      = fifo_mem[rd_ptr_reg];
    assign red_out   = head.red;
    assign green_out = head.green;
    assign blue_out  = head.blue;
    assign alpha_out = head.alpha;
    assign row_end   = head.row_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fifo_cnt_reg) <= bfmd_pkg::FIFO_DEPTH)
        else $error("result queue overfilled");

    a_recip_close: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ({1'b0, s3_rem[0]} < ({1'b0, SUM_W'(area)} << 1)))
        else $error("reciprocal estimate more than one below the quotient");

    a_close_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_close_reg) |=> (s2_valid_reg ##1 s3_valid_reg))
        else $error("closing pixel lost between stages");

    a_cfg_recip: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == bfmd_pkg::ST_RECIP) && pix_stall)
        else $error("configuration write did not restart the reciprocal");

endmodule
`default_nettype wire

### sv/bfmd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfmd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire
